### rtl/lvs_pkg.sv
// Shared constants, state and command types for the line vertex sampler.
`timescale 1ns / 1ps
package lvs_pkg;

   localparam int CoordBits    = 28;
   localparam int StepBits     = 10;
   localparam int StepReset    = 30;
   localparam int RoadBits     = 8;
   localparam int LineBits     = 16;
   localparam int MaxSteps     = 62;
   localparam int SumBits      = 2 * CoordBits + 2;     // even, for the root pairs
   localparam int RootBits     = SumBits / 2;
   localparam int SqRemBits    = RootBits + 3;
   localparam int FracBits     = 4;
   localparam int LenBits      = RootBits - FracBits;
   localparam int QuotBits     = StepBits + FracBits;
   localparam int KBits        = StepBits + CoordBits + FracBits;
   localparam int DispBits     = StepBits + 6;
   localparam int CountBits    = 6;
   localparam int OffBits      = QuotBits + CountBits + 1;
   localparam int IterBits     = 5;
   localparam int ReqDataBits  = 4 * CoordBits;
   localparam int RspDataBits  = 2 * CoordBits + LineBits;
   localparam int RspUserBits  = RoadBits + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SUM,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_ACC_INIT,
      ST_ADV,
      ST_EMIT_START,
      ST_EMIT_MID,
      ST_EMIT_END
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_START,
      EMIT_MID,
      EMIT_END
   } emit_type;

   typedef struct packed {
      logic     load_in;
      logic     prep;
      logic     mul;
      logic     sum;
      logic     sqrt_step;
      logic     div_init;
      logic     div_step;
      logic     acc_init;
      logic     acc_adv;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic mid_ok;
      logic out_free;
   } status_type;

endpackage

### rtl/lvs_ctrl.sv
// Sequencer for the line vertex sampler: steps the datapath through each segment.
`timescale 1ns / 1ps
module lvs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lvs_pkg::status_type status,
   output lvs_pkg::cmd_type    cmd
);
   import lvs_pkg::*;

   state_type            state_ff, state_in;
   logic [IterBits-1:0]  iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_PREP;
         ST_PREP:       state_in = status.skip ? ST_IDLE : ST_MUL;
         ST_MUL:        state_in = ST_SUM;
         ST_SUM: begin
            state_in = ST_SQRT;
            iter_in  = IterBits'(RootBits - 1);
         end
         ST_SQRT: begin
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
            iter_in  = IterBits'(QuotBits - 1);
         end
         ST_DIV: begin
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) state_in = ST_ACC_INIT;
         end
         ST_ACC_INIT:   state_in = ST_ADV;
         ST_ADV:        state_in = ST_EMIT_START;
         ST_EMIT_START: if (status.out_free) state_in = ST_EMIT_MID;
         ST_EMIT_MID:   if (!status.mid_ok) state_in = ST_EMIT_END;
         ST_EMIT_END:   if (status.out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      cmd.emit   = EMIT_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_PREP:     cmd.prep      = 1'b1;
         ST_MUL:      cmd.mul       = 1'b1;
         ST_SUM:      cmd.sum       = 1'b1;
         ST_SQRT:     cmd.sqrt_step = 1'b1;
         ST_DIV_INIT: cmd.div_init  = 1'b1;
         ST_DIV:      cmd.div_step  = 1'b1;
         ST_ACC_INIT: cmd.acc_init  = 1'b1;
         ST_ADV:      cmd.acc_adv   = 1'b1;
         ST_EMIT_START: if (status.out_free) cmd.emit = EMIT_START;
         ST_EMIT_MID: begin
            if (status.mid_ok && status.out_free) begin
               cmd.emit    = EMIT_MID;
               cmd.acc_adv = 1'b1;
            end
         end
         ST_EMIT_END: if (status.out_free) cmd.emit = EMIT_END;
         default: cmd.emit = EMIT_NONE;
      endcase
   end

endmodule

### rtl/lvs_datapath.sv
// Datapath: segment registers, root and divide units, offset stepping, output register.
`timescale 1ns / 1ps
module lvs_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  lvs_pkg::cmd_type                 cmd,
   output lvs_pkg::status_type              status,
   input  logic [lvs_pkg::ReqDataBits-1:0]  req_tdata,
   input  logic [lvs_pkg::RoadBits-1:0]     req_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lvs_pkg::StepBits-1:0]     csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lvs_pkg::RspDataBits-1:0]  rsp_tdata,
   output logic [lvs_pkg::RspUserBits-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);
   import lvs_pkg::*;

   localparam logic [CoordBits-1:0] CoordMax = '1;

   // control state
   logic [StepBits-1:0]  cfg_step_ff;
   logic [LineBits-1:0]  line_ff;
   logic                 valid_ff;

   // segment payload
   logic [CoordBits-1:0] sn_ff, se_ff, tn_ff, te_ff;
   logic [RoadBits-1:0]  road_ff;
   logic [StepBits-1:0]  step_ff;
   logic                 neg_n_ff, neg_e_ff, trunc_ff;
   logic [CoordBits-1:0] dn_ff, de_ff;
   logic [2*CoordBits-1:0] sqn_ff, sqe_ff;
   logic [KBits-1:0]     kn_ff, ke_ff;
   logic [SumBits-1:0]   s_ff;
   logic [SqRemBits-1:0] srem_ff;
   logic [RootBits-1:0]  root_ff;
   logic [RootBits-1:0]  dremn_ff, dreme_ff;
   logic [QuotBits-1:0]  dlown_ff, dlowe_ff, qkn_ff, qke_ff;
   logic [OffBits-1:0]   accqn_ff, accqe_ff;
   logic [RootBits-1:0]  accrn_ff, accre_ff;
   logic [CountBits-1:0] dcnt_ff;
   logic [DispBits-1:0]  disp_ff;
   logic [RspDataBits-1:0] data_ff;
   logic [RspUserBits-1:0] user_ff;
   logic                 last_ff;

   logic [CoordBits-1:0] in_sn, in_se, in_tn, in_te;
   logic [CoordBits-FracBits-1:0] wi, wj, wii, wjj;
   logic                 q_nm, q_pp, q_pm, q_mm;
   logic [SqRemBits-1:0] srem_sh, strial;
   logic [RootBits:0]    dsh_n, dsh_e, rsum_n, rsum_e, h_ext;
   logic [LenBits-1:0]   len;
   logic [DispBits-1:0]  trunc_lim;
   logic [CoordBits-1:0] vtx_n, vtx_e;

   assign in_sn = req_tdata[CoordBits-1:0];
   assign in_se = req_tdata[2*CoordBits-1:CoordBits];
   assign in_tn = req_tdata[3*CoordBits-1:2*CoordBits];
   assign in_te = req_tdata[4*CoordBits-1:3*CoordBits];

   // quadrant from whole metres
   assign wi  = sn_ff[CoordBits-1:FracBits];
   assign wj  = se_ff[CoordBits-1:FracBits];
   assign wii = tn_ff[CoordBits-1:FracBits];
   assign wjj = te_ff[CoordBits-1:FracBits];
   assign q_nm = (wii < wi) && (wjj >= wj);
   assign q_pp = (wii >= wi) && (wjj > wj);
   assign q_pm = (wii > wi) && (wjj <= wj);
   assign q_mm = (wii <= wi) && (wjj < wj);

   assign len       = root_ff[RootBits-1:FracBits];
   assign h_ext     = {1'b0, root_ff};
   assign trunc_lim = DispBits'(step_ff) * DispBits'(MaxSteps + 1);

   assign srem_sh = {srem_ff[SqRemBits-3:0], s_ff[SumBits-1 -: 2]};
   assign strial  = {1'b0, root_ff, 2'b01};
   assign dsh_n   = {dremn_ff, dlown_ff[QuotBits-1]};
   assign dsh_e   = {dreme_ff, dlowe_ff[QuotBits-1]};
   assign rsum_n  = {1'b0, accrn_ff} + {1'b0, dremn_ff};
   assign rsum_e  = {1'b0, accre_ff} + {1'b0, dreme_ff};

   function automatic logic [CoordBits-1:0] apply_off(input logic [CoordBits-1:0] base,
                                                       input logic [OffBits-1:0]   off,
                                                       input logic                 neg);
      logic [CoordBits:0] wide;
      logic [CoordBits:0] offx;
      offx = (CoordBits+1)'(off);
      if (neg) begin
         wide = {1'b0, base} - offx;
         apply_off = (offx > {1'b0, base}) ? '0 : wide[CoordBits-1:0];
      end else begin
         wide = {1'b0, base} + offx;
         apply_off = wide[CoordBits] ? CoordMax : wide[CoordBits-1:0];
      end
   endfunction

   assign vtx_n = apply_off(sn_ff, accqn_ff, neg_n_ff);
   assign vtx_e = apply_off(se_ff, accqe_ff, neg_e_ff);

   assign status.skip     = !(q_nm || q_pp || q_pm || q_mm);
   assign status.mid_ok   = (dcnt_ff <= CountBits'(MaxSteps)) &&
                            (LenBits'(disp_ff) <= len);
   assign status.out_free = !valid_ff || rsp_tready;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_step_ff <= StepBits'(StepReset);
         line_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) cfg_step_ff <= csr_data;
         if (cmd.prep && !status.skip) line_ff <= line_ff + 1'b1;
         if (cmd.emit != EMIT_NONE) valid_ff <= 1'b1;
         else if (rsp_tready)       valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sn_ff   <= in_sn;
         se_ff   <= in_se;
         tn_ff   <= in_tn;
         te_ff   <= in_te;
         road_ff <= req_tuser;
         step_ff <= (cfg_step_ff == '0) ? StepBits'(1) : cfg_step_ff;
      end
      if (cmd.prep) begin
         neg_n_ff <= q_nm || q_mm;
         neg_e_ff <= q_pm || q_mm;
         dn_ff    <= (tn_ff >= sn_ff) ? tn_ff - sn_ff : sn_ff - tn_ff;
         de_ff    <= (te_ff >= se_ff) ? te_ff - se_ff : se_ff - te_ff;
      end
      if (cmd.mul) begin
         sqn_ff <= dn_ff * dn_ff;
         sqe_ff <= de_ff * de_ff;
         kn_ff  <= {(StepBits+CoordBits)'(step_ff * dn_ff), {FracBits{1'b0}}};
         ke_ff  <= {(StepBits+CoordBits)'(step_ff * de_ff), {FracBits{1'b0}}};
      end
      if (cmd.sum) begin
         s_ff    <= SumBits'(sqn_ff) + SumBits'(sqe_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end
      // one root bit a cycle
      if (cmd.sqrt_step) begin
         s_ff <= {s_ff[SumBits-3:0], 2'b00};
         if (srem_sh >= strial) begin
            srem_ff <= srem_sh - strial;
            root_ff <= {root_ff[RootBits-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[RootBits-2:0], 1'b0};
         end
      end
      if (cmd.div_init) begin
         trunc_ff <= (LenBits'(trunc_lim) <= len);
         dremn_ff <= RootBits'(kn_ff[KBits-1:QuotBits]);
         dreme_ff <= RootBits'(ke_ff[KBits-1:QuotBits]);
         dlown_ff <= kn_ff[QuotBits-1:0];
         dlowe_ff <= ke_ff[QuotBits-1:0];
      end
      // one quotient bit a cycle for both axes; quotient lands in dlow
      if (cmd.div_step) begin
         if (dsh_n >= h_ext) begin
            dremn_ff <= RootBits'(dsh_n - h_ext);
            dlown_ff <= {dlown_ff[QuotBits-2:0], 1'b1};
         end else begin
            dremn_ff <= RootBits'(dsh_n);
            dlown_ff <= {dlown_ff[QuotBits-2:0], 1'b0};
         end
         if (dsh_e >= h_ext) begin
            dreme_ff <= RootBits'(dsh_e - h_ext);
            dlowe_ff <= {dlowe_ff[QuotBits-2:0], 1'b1};
         end else begin
            dreme_ff <= RootBits'(dsh_e);
            dlowe_ff <= {dlowe_ff[QuotBits-2:0], 1'b0};
         end
      end
      if (cmd.acc_init) begin
         qkn_ff   <= dlown_ff;
         qke_ff   <= dlowe_ff;
         accqn_ff <= '0;
         accqe_ff <= '0;
         accrn_ff <= root_ff >> 1;
         accre_ff <= root_ff >> 1;
         dcnt_ff  <= '0;
         disp_ff  <= '0;
      end
      // advance to the next displacement: quotient plus carried remainder
      if (cmd.acc_adv) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         disp_ff <= disp_ff + DispBits'(step_ff);
         if (rsum_n >= h_ext) begin
            accrn_ff <= RootBits'(rsum_n - h_ext);
            accqn_ff <= accqn_ff + OffBits'(qkn_ff) + 1'b1;
         end else begin
            accrn_ff <= RootBits'(rsum_n);
            accqn_ff <= accqn_ff + OffBits'(qkn_ff);
         end
         if (rsum_e >= h_ext) begin
            accre_ff <= RootBits'(rsum_e - h_ext);
            accqe_ff <= accqe_ff + OffBits'(qke_ff) + 1'b1;
         end else begin
            accre_ff <= RootBits'(rsum_e);
            accqe_ff <= accqe_ff + OffBits'(qke_ff);
         end
      end
      case (cmd.emit)
         EMIT_START: begin
            data_ff <= {line_ff, se_ff, sn_ff};
            user_ff <= {trunc_ff, road_ff, 1'b1};
            last_ff <= 1'b0;
         end
         EMIT_MID: begin
            data_ff <= {line_ff, vtx_e, vtx_n};
            user_ff <= {trunc_ff, road_ff, 1'b0};
            last_ff <= 1'b0;
         end
         EMIT_END: begin
            data_ff <= {line_ff, te_ff, tn_ff};
            user_ff <= {trunc_ff, road_ff, 1'b1};
            last_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/line_vertex_sampler_core.sv
// Top level of the line vertex sampler: sequencer plus datapath.
`timescale 1ns / 1ps
// Usage
//  - req_*: one transfer carries one segment (start and target in 1/16 m)
//    and its road code. The core takes one segment at a time; req_tready
//    is high only while it waits for a segment.
//  - rsp_*: the vertices of the segment, start first, then the intermediate
//    points at multiples of the spacing, then the target with tlast set.
//    A segment whose whole-metre start and target coincide gives no
//    transfer and leaves the line number unchanged.
//  - csr_*: writes the step spacing in metres (0 acts as 1); always ready.
//    Write it only while the core is idle.
//  - Order of work: accept, prepare, multiply, sum, the bit-serial square
//    root, divider set-up, the bit-serial divider for both axes, then
//    accumulator set-up and the first advance before the start vertex is
//    registered. The start and intermediate vertices then leave one per
//    cycle while the receiver takes them; a segment gives up to 64
//    vertices, the target last.
//  - A stalled receiver holds the output register; the core waits without
//    losing or repeating a vertex.
//  - Synchronous reset clears the line counter and sets the spacing to 30.
module line_vertex_sampler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_north, start_east, target_north, target_east
   input  logic [lvs_pkg::ReqDataBits-1:0]   req_tdata,
   // road_code
   input  logic [lvs_pkg::RoadBits-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // vertex_north, vertex_east, line_number
   output logic [lvs_pkg::RspDataBits-1:0]   rsp_tdata,
   // is_endpoint, road_type, truncated
   output logic [lvs_pkg::RspUserBits-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lvs_pkg::StepBits-1:0]      csr_data
);
   import lvs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence the segment
   lvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the arithmetic and the output register
   lvs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/lvs_checker.sv
// Port-level checks for the line vertex sampler, bound to the top level.
`timescale 1ns / 1ps
module lvs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lvs_pkg::RspDataBits-1:0]  rsp_tdata,
   input logic [lvs_pkg::RspUserBits-1:0]  rsp_tuser,
   input logic                             rsp_tlast
);
   import lvs_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one segment at a time
   a_one_segment: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second segment taken while busy");

   // the final vertex is the target endpoint
   a_last_endpoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("final vertex not marked as endpoint");

endmodule

bind line_vertex_sampler_core lvs_checker u_lvs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### bench/tb_line_vertex_sampler_core.sv
// Testbench for the line vertex sampler core: directed and random segments checked against a local predictor.
`timescale 1ns / 1ps
module tb_line_vertex_sampler_core;
   import lvs_pkg::*;

   localparam logic [27:0] CoordMax = 28'hFFFFFFF;

   typedef struct packed {
      logic [27:0] vn;
      logic [27:0] ve;
      logic        endp;
      logic [7:0]  road;
      logic [15:0] line;
      logic        trunc;
      logic        last;
   } vertex_type;

   // Vertex predictor and store of expected vertices.
   class vertex_board;
      vertex_type  pending[$];
      logic [9:0]  spacing;
      logic [15:0] lines;
      int          errors;

      function new();
         spacing = 10'd30;
         lines   = 0;
         errors  = 0;
      endfunction

      function logic [63:0] root_of(logic [63:0] v);
         logic [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [27:0] shift_pos(logic [27:0] base, logic [63:0] off, bit neg);
         logic [63:0] s;
         if (neg) return (off > base) ? 28'd0 : base - off[27:0];
         s = base + off;
         return (s > CoordMax) ? CoordMax : s[27:0];
      endfunction

      function void note_segment(logic [27:0] sn, logic [27:0] se, logic [27:0] tn,
                                 logic [27:0] te, logic [7:0] road);
         logic [27:0] i, j, ii, jj;
         logic [63:0] dn, de, h, cnt, step, disp, offn, offe;
         bit negn, nege, tr;
         vertex_type v;
         i = sn >> 4; j = se >> 4; ii = tn >> 4; jj = te >> 4;
         if (ii < i && jj >= j) begin negn = 1; nege = 0; end
         else if (ii >= i && jj > j) begin negn = 0; nege = 0; end
         else if (ii > i && jj <= j) begin negn = 0; nege = 1; end
         else if (ii <= i && jj < j) begin negn = 1; nege = 1; end
         else return;
         dn = (tn >= sn) ? tn - sn : sn - tn;
         de = (te >= se) ? te - se : se - te;
         h = root_of(dn * dn + de * de);
         if (h == 0) h = 1;
         step = (spacing == 0) ? 1 : spacing;
         cnt = (h >> 4) / step;
         tr = 0;
         if (cnt > MaxSteps) begin cnt = MaxSteps; tr = 1; end
         lines++;
         v = '{sn, se, 1'b1, road, lines, tr, 1'b0};
         pending.push_back(v);
         for (int d = 1; d <= cnt; d++) begin
            disp = d * step * 16;
            offn = (disp * dn + (h >> 1)) / h;
            offe = (disp * de + (h >> 1)) / h;
            v = '{shift_pos(sn, offn, negn), shift_pos(se, offe, nege), 1'b0,
                  road, lines, tr, 1'b0};
            pending.push_back(v);
         end
         v = '{tn, te, 1'b1, road, lines, tr, 1'b1};
         pending.push_back(v);
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type w;
         if (pending.size() == 0) begin
            $error("unexpected vertex %p", got);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.vn !== w.vn) begin $error("vertex_north exp %0d got %0d", w.vn, got.vn); errors++; end
         if (got.ve !== w.ve) begin $error("vertex_east exp %0d got %0d", w.ve, got.ve); errors++; end
         if (got.endp !== w.endp) begin $error("is_endpoint exp %0d got %0d", w.endp, got.endp); errors++; end
         if (got.road !== w.road) begin $error("road_type exp %0d got %0d", w.road, got.road); errors++; end
         if (got.line !== w.line) begin $error("line_number exp %0d got %0d", w.line, got.line); errors++; end
         if (got.trunc !== w.trunc) begin $error("truncated exp %0d got %0d", w.trunc, got.trunc); errors++; end
         if (got.last !== w.last) begin $error("last exp %0d got %0d", w.last, got.last); errors++; end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic [RoadBits-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic [RspUserBits-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   logic [StepBits-1:0]    csr_data = '0;

   vertex_board board = new();
   bit          calm;       // no idling on either side
   bit          hold_off;   // long receiver stall

   line_vertex_sampler_core uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Check each vertex transfer; the receiver idles at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_vertex('{rsp_tdata[27:0], rsp_tdata[55:28], rsp_tuser[0],
                                 rsp_tuser[8:1], rsp_tdata[71:56], rsp_tuser[9],
                                 rsp_tlast});
         rsp_tready <= !hold_off && (calm || $urandom_range(99) >= 25);
      end
   end

   task automatic send_segment(logic [27:0] sn, logic [27:0] se, logic [27:0] tn,
                               logic [27:0] te, logic [7:0] road);
      while (!calm && $urandom_range(99) < 25) @(posedge clock);
      req_tvalid <= 1;
      req_tdata  <= {te, tn, se, sn};
      req_tuser  <= road;
      do @(posedge clock); while (!req_tready);
      board.note_segment(sn, se, tn, te, road);
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_spacing(logic [9:0] value);
      drain();
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.spacing = value;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Random segment: mostly short, some long, a few of any size.
   task automatic random_segment();
      logic [27:0] sn, se, tn, te;
      int r;
      sn = 28'($urandom); se = 28'($urandom);
      r = int'($urandom_range(9));
      if (r < 6) begin
         tn = 28'(sn + $urandom_range(4000) - 2000);
         te = 28'(se + $urandom_range(4000) - 2000);
      end else if (r < 8) begin
         tn = 28'(sn + ($urandom & 28'h3FFFF) - 28'h1FFFF);
         te = 28'(se + ($urandom & 28'h3FFFF) - 28'h1FFFF);
      end else begin
         tn = 28'($urandom); te = 28'($urandom);
      end
      if ($urandom_range(19) == 0) begin tn = sn ^ 28'($urandom_range(15)); te = se; end
      send_segment(sn, se, tn, te, 8'($urandom));
   endtask

   initial begin
      calm = 0;
      hold_off = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: quadrants, extremes, same point, truncation, saturation
      send_segment(28'd1600, 28'd1600, 28'd0, 28'd3200, 8'h00);
      send_segment(28'd1600, 28'd1600, 28'd3200, 28'd3200, 8'hFF);
      send_segment(28'd1600, 28'd1600, 28'd3200, 28'd0, 8'h55);
      send_segment(28'd1600, 28'd1600, 28'd0, 28'd0, 8'hAA);
      send_segment(28'd1600, 28'd1600, 28'd1615, 28'd1609, 8'h01);
      send_segment(28'd0, 28'd0, CoordMax, CoordMax, 8'h80);
      send_segment(CoordMax, CoordMax, 28'd0, 28'd0, 8'h7F);
      send_segment(CoordMax, 28'd0, 28'd0, CoordMax, 8'h12);
      send_segment(28'd31, 28'd31, 28'd16, 28'd800, 8'h34);
      send_segment(CoordMax - 28'd15, 28'd100, CoordMax, 28'd900, 8'h56);
      send_segment(28'd17, 28'd5000, 28'd0, 28'd5100, 8'h77);
      write_spacing(10'd0);
      send_segment(28'd0, 28'd0, 28'd300, 28'd400, 8'h21);
      send_segment(28'd1000, 28'd1000, 28'd1016, 28'd1000, 8'h22);
      write_spacing(10'd1023);
      send_segment(28'd0, 28'd0, CoordMax, CoordMax, 8'h23);
      send_segment(28'd0, 28'd0, 28'd16368, 28'd0, 8'h24);
      write_spacing(10'd1);
      send_segment(28'd500, 28'd500, 28'd900, 28'd100, 8'h25);
      // fill the core while the receiver holds off
      hold_off = 1;
      fork
         begin repeat (400) @(posedge clock); hold_off = 0; end
         repeat (3) random_segment();
      join
      // sender pause until all vertices are back
      drain();
      for (int p = 0; p < 5; p++) begin
         if (p == 2) calm = 1;
         if (p == 3) calm = 0;
         write_spacing(p == 4 ? 10'd1023 : 10'($urandom_range(1, 60)));
         repeat (48) random_segment();
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_line_vertex_sampler_core: clean");
      else
         $display("tb_line_vertex_sampler_core: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_line_vertex_sampler_core: errors");
      $finish;
   end
endmodule

### line_vertex_sampler_core.f
rtl/lvs_pkg.sv
rtl/lvs_ctrl.sv
rtl/lvs_datapath.sv
rtl/line_vertex_sampler_core.sv
rtl/lvs_checker.sv
bench/tb_line_vertex_sampler_core.sv
